// ===== rtl/core/cltw_pkg.sv =====
// ----------------------------------------------------------------------------
// cltw_pkg: shared types and constants of the character LCD text writer
// Holds the channel payload structs, the action codes, the register indexes
// and the job record that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package cltw_pkg;

	// Action codes of an input item.
	localparam logic [1:0] ACT_SET_POS = 2'd0;
	localparam logic [1:0] ACT_CHAR    = 2'd1;
	localparam logic [1:0] ACT_CMD     = 2'd2;
	localparam logic [1:0] ACT_NIBBLE  = 2'd3;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
	localparam logic [5:0] COLUMNS_RESET = 6'd16;
	localparam logic [1:0] ROWS_RESET    = 2'd2;

	// Bit positions inside the shift word.
	localparam int unsigned BIT_E  = 3;
	localparam int unsigned BIT_RS = 2;

	// A job carries up to four nibbles (two bytes).
	localparam int unsigned JOB_NIBS  = 4;
	localparam int unsigned NIB_IDX_W = 2;
	localparam int unsigned NIB_CNT_W = 3;

	// Job queue between the front and the back part.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] row;
		logic [5:0] col;
		logic [7:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] shift_word;
		logic       last;
	} word_t;

	typedef struct packed {
		logic [NIB_CNT_W-1:0]           nib_cnt;
		logic [JOB_NIBS-1:0]            rs;
		logic [JOB_NIBS-1:0][3:0]       nibs;
	} job_t;

endpackage

// ===== rtl/core/char_lcd_text_writer_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_text_writer_unit: character LCD text writer, 4-bit nibble interface
// Turns text, position and command items into the shift words that drive a
// character display in 4-bit mode through an 8-bit shift register.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload            Direction
//   -------   -----------------------   ----------------   ---------
//   item      item_valid / item_ready   cltw_pkg::item_t   in
//   word      word_valid / word_ready   cltw_pkg::word_t   out
//   cfg       cfg_we (no wait)          cfg_index/data     in
//
// An item is taken whenever the job queue has room; it yields
// three to twelve words, or none for a rejected position or a dropped character.
// Words are issued at one per cycle while word_ready is high, so the output port
// sets the sustained rate; each nibble goes out as three words (up to twelve per item).
// Reset clears the cursor to row zero, column zero with text enabled and
// loads 16 columns and 2 rows; it takes effect at once with no clearing pass.
// A stalled word output fills the four-entry job queue before item_ready falls;
// items that produce no words (rejected positions, dropped characters) still
// need a free queue slot to be taken.
//
// The front part checks the position limits, advances the cursor and builds a
// job of up to four nibbles. The back part walks the nibbles of the head job
// and places each word in an output register, so a finished word can wait for
// its transfer while the next one is prepared.
// ----------------------------------------------------------------------------
module char_lcd_text_writer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cltw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  cltw_pkg::item_t                 item,
	output logic                            word_valid,
	input  logic                            word_ready,
	output cltw_pkg::word_t                 word
);

	// Jobs travel from the front part into the queue and out to the back part.
	logic           job_push;
	cltw_pkg::job_t push_job;
	logic           queue_full;
	logic           job_pop;
	logic           head_valid;
	cltw_pkg::job_t head_job;

	// Front part: takes items, tracks the cursor and holds the registers.
	cltw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (push_job)
	);

	// The queue lets the front keep taking items while words are stalled.
	cltw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back part: emits each nibble as three words and marks the final one.
	cltw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (head_valid),
		.job        (head_job),
		.job_pop    (job_pop),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word)
	);

endmodule

// ===== rtl/core/cltw_front.sv =====
// ----------------------------------------------------------------------------
// cltw_front: item classification and cursor tracking
// Holds the configuration registers and the text position, and turns each
// accepted item into a job of nibbles for the back part.
// ----------------------------------------------------------------------------
module cltw_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cltw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  cltw_pkg::item_t                 item,
	input  logic                            queue_full,
	output logic                            job_push,
	output cltw_pkg::job_t                  job
);

	logic [5:0] columns_q;
	logic [1:0] rows_q;
	logic [1:0] cursor_row_q;
	logic [5:0] cursor_col_q;
	logic       text_en_q;

	logic       accept;
	logic       set_ok;
	logic       char_ok;
	logic [6:0] next_col;
	logic       wrap;
	logic [1:0] next_row;
	logic       wrap_cmd;
	logic [7:0] set_byte;
	logic [7:0] wrap_byte;
	logic       has_words;

	assign item_ready = !queue_full;
	assign accept     = item_valid && item_ready;

	assign set_ok   = (item.row < rows_q) && (item.col < columns_q);
	assign char_ok  = text_en_q && (cursor_row_q < rows_q);
	assign next_col = {1'b0, cursor_col_q} + 7'd1;
	assign wrap     = next_col >= {1'b0, columns_q};
	assign next_row = cursor_row_q + 2'd1;
	assign wrap_cmd = wrap && (next_row < rows_q);

	// Address command: 0x80 plus the column, plus 0x40 on any row but the first.
	assign set_byte  = {1'b1, item.row != 2'd0, item.col};
	assign wrap_byte = {1'b1, next_row != 2'd0, 6'd0};

	always_comb begin
		job       = '0;
		has_words = 1'b0;
		unique case (item.action)
			cltw_pkg::ACT_SET_POS: begin
				has_words   = set_ok;
				job.nib_cnt = 3'd2;
				job.nibs[0] = set_byte[7:4];
				job.nibs[1] = set_byte[3:0];
			end
			cltw_pkg::ACT_CHAR: begin
				has_words   = char_ok;
				job.nib_cnt = wrap_cmd ? 3'd4 : 3'd2;
				job.rs      = 4'b0011;
				job.nibs[0] = item.value[7:4];
				job.nibs[1] = item.value[3:0];
				job.nibs[2] = wrap_byte[7:4];
				job.nibs[3] = wrap_byte[3:0];
			end
			cltw_pkg::ACT_CMD: begin
				has_words   = 1'b1;
				job.nib_cnt = 3'd2;
				job.nibs[0] = item.value[7:4];
				job.nibs[1] = item.value[3:0];
			end
			cltw_pkg::ACT_NIBBLE: begin
				has_words   = 1'b1;
				job.nib_cnt = 3'd1;
				job.nibs[0] = item.value[3:0];
			end
			default: begin
				has_words = 1'b0;
			end
		endcase
	end

	assign job_push = accept && has_words;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= cltw_pkg::COLUMNS_RESET;
			rows_q    <= cltw_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == cltw_pkg::CFG_COLUMNS) begin
				columns_q <= cfg_data[5:0];
			end else if (cfg_index == cltw_pkg::CFG_ROWS) begin
				rows_q <= cfg_data[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= 2'd0;
			cursor_col_q <= 6'd0;
			text_en_q    <= 1'b1;
		end else if (accept) begin
			if (item.action == cltw_pkg::ACT_SET_POS) begin
				text_en_q <= set_ok;
				if (set_ok) begin
					cursor_row_q <= item.row;
					cursor_col_q <= item.col;
				end
			end else if (item.action == cltw_pkg::ACT_CHAR && char_ok) begin
				if (wrap) begin
					cursor_row_q <= next_row;
					cursor_col_q <= 6'd0;
				end else begin
					cursor_col_q <= next_col[5:0];
				end
			end
		end
	end

endmodule

// ===== rtl/core/cltw_queue.sv =====
// ----------------------------------------------------------------------------
// cltw_queue: job queue between the front and the back part
// A four-entry first-in first-out store of job records.
// ----------------------------------------------------------------------------
module cltw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cltw_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output cltw_pkg::job_t head_job
);

	cltw_pkg::job_t                    mem_q [cltw_pkg::QUEUE_DEPTH];
	logic [cltw_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [cltw_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [cltw_pkg::QCNT_W-1:0]       count_q;

	assign full       = count_q == cltw_pkg::QCNT_W'(cltw_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/cltw_back.sv =====
// ----------------------------------------------------------------------------
// cltw_back: nibble sequencer and output register
// Sends each nibble of the head job as three words (E low, high, low) and
// releases the job with its final word.
// ----------------------------------------------------------------------------
module cltw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  cltw_pkg::job_t  job,
	output logic            job_pop,
	output logic            word_valid,
	input  logic            word_ready,
	output cltw_pkg::word_t word
);

	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_DROP = 2'd2;

	logic [1:0]                     phase_q;
	logic [cltw_pkg::NIB_IDX_W-1:0] nib_idx_q;
	logic                           word_valid_q;
	cltw_pkg::word_t                word_q;

	logic                           load;
	logic                           nib_done;
	logic                           job_done;
	logic [3:0]                     nib;
	logic [7:0]                     next_word;

	assign load     = job_valid && (!word_valid_q || word_ready);
	assign nib_done = phase_q == PH_DROP;
	assign job_done = nib_done &&
		({1'b0, nib_idx_q} == job.nib_cnt - 3'd1);
	assign job_pop  = load && job_done;

	assign nib = job.nibs[nib_idx_q];

	always_comb begin
		next_word                   = {nib, 4'b0000};
		next_word[cltw_pkg::BIT_E]  = phase_q == PH_HIGH;
		next_word[cltw_pkg::BIT_RS] = job.rs[nib_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LOW;
			nib_idx_q    <= '0;
			word_valid_q <= 1'b0;
		end else begin
			if (load) begin
				word_valid_q <= 1'b1;
			end else if (word_ready) begin
				word_valid_q <= 1'b0;
			end
			if (load) begin
				unique case (phase_q)
					PH_LOW:  phase_q <= PH_HIGH;
					PH_HIGH: phase_q <= PH_DROP;
					PH_DROP: phase_q <= PH_LOW;
					default: phase_q <= PH_LOW;
				endcase
				if (job_done) begin
					nib_idx_q <= '0;
				end else if (nib_done) begin
					nib_idx_q <= nib_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.shift_word <= next_word;
			word_q.last       <= job_done;
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

endmodule

// ===== rtl/core/cltw_checker.sv =====
// ----------------------------------------------------------------------------
// cltw_checker: port-level checks of the character LCD text writer
// Watches the word channel for handshake and word-format slips.
// ----------------------------------------------------------------------------
module cltw_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            word_valid,
	input  logic            word_ready,
	input  cltw_pkg::word_t word
);

	// A stalled word stays offered and unchanged.
	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_ready |=> word_valid && $stable(word))
		else $error("word changed or dropped while stalled");

	// The two low bits of a shift word are never driven.
	a_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> word.shift_word[1:0] == 2'b00)
		else $error("shift word low bits not zero");

	// The final word of an item always leaves the enable strobe low.
	a_last_e_low: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word.last |-> !word.shift_word[cltw_pkg::BIT_E])
		else $error("final word carries enable high");

	// A transferred strobe word is followed by the same nibble with E low.
	a_strobe_drop: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_ready && word.shift_word[cltw_pkg::BIT_E] |=>
		word_valid && !word.shift_word[cltw_pkg::BIT_E] &&
		word.shift_word[7:4] == $past(word.shift_word[7:4]))
		else $error("enable strobe not followed by its falling word");

endmodule

bind char_lcd_text_writer_unit cltw_checker u_cltw_checker (.*);
